>>> design/date_add_days_assert.svh
// ----------------------------------------------------------------------------
// date_add_days_assert.svh
// Assertion macros shared by the date adder checker.
// ----------------------------------------------------------------------------
`ifndef DATE_ADD_DAYS_ASSERT_SVH
`define DATE_ADD_DAYS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define DAD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define DAD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg
// Widths, calendar constants, command/status types and month helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dad_pkg;

    // Field widths
    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int ADD_W  = 16;
    // Year carried one bit wider so a carry past the field wraps only at output
    localparam int YEARX_W = YEAR_W + 1;
    // Day accumulator holds day plus the full day count
    localparam int ACC_W  = ADD_W + 1;
    // Controller step counter
    localparam int CNT_W  = 3;

    // Calendar constants
    localparam logic [YEAR_W-1:0] MIN_YEAR = YEAR_W'(1601);
    localparam int                CYCLE_YEARS = 400;
    localparam int                REDUCE_STEPS = 6;
    // Largest multiple of 400 tried first: 400 shifted up by five
    localparam logic [YEAR_W-1:0] REDUCE_TOP = YEAR_W'(CYCLE_YEARS * 32);
    localparam logic [YEAR_W-1:0] CYCLE_LAST = YEAR_W'(CYCLE_YEARS - 1);
    localparam logic [YEAR_W-1:0] CENT_1 = YEAR_W'(100);
    localparam logic [YEAR_W-1:0] CENT_2 = YEAR_W'(200);
    localparam logic [YEAR_W-1:0] CENT_3 = YEAR_W'(300);

    // Month codes
    localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MON_MAR = MON_W'(3);
    localparam logic [MON_W-1:0] MON_APR = MON_W'(4);
    localparam logic [MON_W-1:0] MON_MAY = MON_W'(5);
    localparam logic [MON_W-1:0] MON_JUN = MON_W'(6);
    localparam logic [MON_W-1:0] MON_JUL = MON_W'(7);
    localparam logic [MON_W-1:0] MON_AUG = MON_W'(8);
    localparam logic [MON_W-1:0] MON_SEP = MON_W'(9);
    localparam logic [MON_W-1:0] MON_OCT = MON_W'(10);
    localparam logic [MON_W-1:0] MON_NOV = MON_W'(11);
    localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic reduce;
        logic check;
        logic norm;
    } dad_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic date_ok;
        logic fits;
    } dad_stat_t;

    // Leap test from the low year bits and the year modulo 400
    function automatic logic is_leap(input logic [1:0] ylo, input logic [YEAR_W-1:0] r400);
        is_leap = (ylo == 2'd0) && (r400 != CENT_1) && (r400 != CENT_2) && (r400 != CENT_3);
    endfunction

    // Month length; months outside 1 to 12 read as zero
    function automatic logic [DAY_W-1:0] days_in(input logic [MON_W-1:0] m, input logic leap);
        logic [DAY_W-1:0] len;
        len = DAY_W'(31);
        unique case (m)
            MON_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAY_W'(30);
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC:
                len = DAY_W'(31);
            default: len = DAY_W'(0);
        endcase
        days_in = len;
    endfunction

endpackage

>>> design/dad_ctrl.sv
// ----------------------------------------------------------------------------
// dad_ctrl
// Sequencer: year reduction, date check, month-by-month normalization.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dad_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dad_pkg::dad_stat_t stat,
    output dad_pkg::dad_cmd_t  cmd,
    output logic              busy,
    output logic              done
);
    import dad_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_NORM   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [CNT_W-1:0] REDUCE_LAST = CNT_W'(REDUCE_STEPS - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == REDUCE_LAST)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.date_ok ? ST_NORM : ST_DONE;
            end
            ST_NORM:
            begin
                if (stat.fits)
                    state_next = ST_DONE;
                else
                    cmd.norm = 1'b1;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

>>> design/dad_datapath.sv
// ----------------------------------------------------------------------------
// dad_datapath
// Date registers, year-modulo-400 reduction and one-month subtract step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dad_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dad_pkg::dad_cmd_t             cmd,
    input  logic [dad_pkg::DAY_W-1:0]     day,
    input  logic [dad_pkg::MON_W-1:0]     month,
    input  logic [dad_pkg::YEAR_W-1:0]    year,
    input  logic [dad_pkg::ADD_W-1:0]     add_days,
    output dad_pkg::dad_stat_t            stat,
    output logic                          in_valid,
    output logic [dad_pkg::DAY_W-1:0]     res_day,
    output logic [dad_pkg::MON_W-1:0]     res_month,
    output logic [dad_pkg::YEAR_W-1:0]    res_year
);
    import dad_pkg::*;

    logic [ACC_W-1:0]   d_reg;
    logic [MON_W-1:0]   m_reg;
    logic [YEARX_W-1:0] y_reg;
    logic [ADD_W-1:0]   n_reg;
    logic [YEAR_W-1:0]  r_reg;
    logic [YEAR_W-1:0]  sub_reg;
    logic               ok_reg;

    logic             leap;
    logic [DAY_W-1:0] len;
    logic             mon_ok;
    logic             year_ok;

    // Month length of the current date
    assign leap = is_leap(y_reg[1:0], r_reg);
    assign len  = days_in(m_reg, leap);

    // Range checks on the loaded date
    assign mon_ok  = (m_reg >= MON_JAN) && (m_reg <= MON_DEC);
    assign year_ok = (y_reg >= YEARX_W'(MIN_YEAR));

    assign stat.date_ok = year_ok && mon_ok && (d_reg != '0) && (d_reg <= ACC_W'(len));
    assign stat.fits    = (d_reg <= ACC_W'(len));

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ok_reg <= 1'b0;
        else if (cmd.check)
            ok_reg <= stat.date_ok;
    end

    // Load, reduce, add and step through months
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg   <= ACC_W'(day);
            m_reg   <= month;
            y_reg   <= YEARX_W'(year);
            n_reg   <= add_days;
            r_reg   <= year;
            sub_reg <= REDUCE_TOP;
        end
        else if (cmd.reduce)
        begin
            if (r_reg >= sub_reg)
                r_reg <= r_reg - sub_reg;
            sub_reg <= sub_reg >> 1;
        end
        else if (cmd.check)
        begin
            if (stat.date_ok)
                d_reg <= d_reg + ACC_W'(n_reg);
        end
        else if (cmd.norm)
        begin
            d_reg <= d_reg - ACC_W'(len);
            if (m_reg == MON_DEC)
            begin
                m_reg <= MON_JAN;
                y_reg <= y_reg + YEARX_W'(1);
                r_reg <= (r_reg == CYCLE_LAST) ? '0 : r_reg + YEAR_W'(1);
            end
            else
            begin
                m_reg <= m_reg + MON_W'(1);
            end
        end
    end

    assign in_valid  = ok_reg;
    assign res_day   = d_reg[DAY_W-1:0];
    assign res_month = m_reg;
    assign res_year  = y_reg[YEAR_W-1:0];

endmodule

>>> design/date_add_days.sv
// Sequence: an item transfers at start with busy low; the year is then reduced
// modulo 400, the date is checked and, for a valid date, the day count is added
// and months are stepped one per cycle until the day fits, up to about 2160
// months for the largest day count; done then pulses. An invalid date goes to
// done straight after the check. Throughput: one item at a time, none while busy.
// Reset: rst_n low returns the sequencer to idle and clears done and busy.
// ----------------------------------------------------------------------------
// date_add_days
// Adds a day count to a Gregorian date with validity check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module date_add_days (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [dad_pkg::DAY_W-1:0]  day,
    input  logic [dad_pkg::MON_W-1:0]  month,
    input  logic [dad_pkg::YEAR_W-1:0] year,
    input  logic [dad_pkg::ADD_W-1:0]  add_days,
    output logic                       done,
    output logic                       in_valid,
    output logic [dad_pkg::DAY_W-1:0]  res_day,
    output logic [dad_pkg::MON_W-1:0]  res_month,
    output logic [dad_pkg::YEAR_W-1:0] res_year
);
    import dad_pkg::*;

    dad_cmd_t  cmd;
    dad_stat_t stat;
    logic      busy_int;

    // Sequencer
    dad_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy_int),
        .done  (done)
    );

    // Date arithmetic
    dad_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .day       (day),
        .month     (month),
        .year      (year),
        .add_days  (add_days),
        .stat      (stat),
        .in_valid  (in_valid),
        .res_day   (res_day),
        .res_month (res_month),
        .res_year  (res_year)
    );

    assign busy = busy_int;

endmodule

>>> design/dad_checker.sv
// ----------------------------------------------------------------------------
// dad_checker
// Port-level checks on the date adder: strobe timing and result range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "date_add_days_assert.svh"

module dad_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic                       in_valid,
    input logic [dad_pkg::DAY_W-1:0]  res_day,
    input logic [dad_pkg::MON_W-1:0]  res_month
);
    import dad_pkg::*;

    // A transfer makes the block busy next cycle
    `DAD_ASSERT_NXT(a_start_busy, start && !busy, busy, "transfer did not raise busy")
    // Result strobe lasts one cycle and frees the block
    `DAD_ASSERT_NXT(a_done_pulse, done, !done && !busy, "done not a single-cycle pulse")
    // Result only while an item is in work
    `DAD_ASSERT_IMP(a_done_busy, done, busy, "done without an item in work")
    // A valid result is a real calendar day
    `DAD_ASSERT_IMP(a_res_range, done && in_valid,
        (res_day != '0) && (res_month >= MON_JAN) && (res_month <= MON_DEC),
        "valid result outside calendar range")

endmodule

bind date_add_days dad_checker u_dad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .in_valid  (in_valid),
    .res_day   (res_day),
    .res_month (res_month)
);
